// ===== design/smt_pkg.sv =====
// Shared types and constants for the sorted multiset table.
`timescale 1ns / 1ps

package smt_pkg;

    localparam int ELEM_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

// ===== design/smt_ram.sv =====
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module smt_ram
    import smt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  elem_t         wdata,
    input  logic [AW-1:0] raddr,
    output elem_t         rdata
);

    elem_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sorted_multiset_table_core.sv =====
// Top level: sequencer of the sorted multiset table around the element store.
`timescale 1ns / 1ps

// Bounded multiset of signed 32-bit values, held in ascending order.
// Request words come in on the s_ group: s_tuser carries the operation
// (insert, remove, search, count) and s_tdata the value. One result word per
// request leaves on the m_ group.
// A request walks the store one entry per cycle through a single read port
// and one shared signed compare:
//   insert : walks down from the top, moving each entry not smaller than the
//            value up one place; an insert into a full or empty store does not walk.
//   remove : scans from the bottom; once the value is found it runs on to the
//            top entry, closing the gap behind the removed word.
//   search : scans up to the first entry not smaller than the value.
//   count  : scans up to the first entry larger than the value.
// s_tready is high only while the sequencer is idle. A finished result is
// held in the output register; while the receiver stalls, the next request
// may still be taken, and its result waits until the previous word has gone.
// Reset empties the store at once (count cleared, contents not touched).
module sorted_multiset_table_core
    import smt_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int M_W     = ((3 + 2 * CNT_W) + 7) / 8 * 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,   // value
    input  logic [1:0]     s_tuser,   // req_type
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata    // hit, occurrences, size, empty_res, rejected
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_LAST,
        ST_FWD_SCAN,
        ST_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int PAD_W = M_W - (3 + 2 * CNT_W);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    elem_t            val_reg, val_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic             hit_reg, hit_next;
    logic             rej_reg, rej_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]   m_tdata_reg, m_tdata_next;

    logic             we;
    logic [AW-1:0]    waddr;
    elem_t            wdata;
    logic [AW-1:0]    raddr;
    elem_t            rdata;

    logic             cmp_lt, cmp_eq, cmp_gt;
    logic             scan_last;
    logic [CNT_W-1:0] cnt_m1;
    logic             s_acc;

    smt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // shared compare of the word just read against the request value
    assign cmp_lt    = rdata < val_reg;
    assign cmp_eq    = rdata == val_reg;
    assign cmp_gt    = !cmp_lt && !cmp_eq;
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign scan_last = {{(CNT_W - AW){1'b0}}, idx_reg} == cnt_m1;

    assign s_tready  = state_reg == ST_IDLE;
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        rej_next      = rej_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        waddr         = idx_reg + AW'(1);
        wdata         = rdata;
        raddr         = idx_reg + AW'(1);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                raddr = '0;
                if (s_acc)
                begin
                    op_next    = op_t'(s_tuser);
                    val_next   = s_tdata;
                    occ_next   = '0;
                    hit_next   = 1'b0;
                    rej_next   = 1'b0;
                    found_next = 1'b0;
                    if (op_t'(s_tuser) == OP_INSERT)
                    begin
                        if (cnt_reg == CAP_CNT)
                        begin
                            rej_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else if (cnt_reg == '0)
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = s_tdata;
                            cnt_next   = CNT_W'(1);
                            hit_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            // walk down from the top entry
                            raddr      = cnt_m1[AW-1:0];
                            idx_next   = cnt_m1[AW-1:0];
                            state_next = ST_INS_SCAN;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_FWD_SCAN;
                    end
                end
            end

            ST_INS_SCAN:
            begin
                we = 1'b1;
                if (!cmp_lt)
                begin
                    // move the word up one place
                    raddr = idx_reg - AW'(1);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wdata      = val_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_INS_LAST:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = val_reg;
                cnt_next   = cnt_reg + CNT_W'(1);
                hit_next   = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FWD_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
                case (op_reg)
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            // close the gap behind the removed word
                            we    = 1'b1;
                            waddr = idx_reg - AW'(1);
                        end
                        if (found_reg || cmp_eq)
                        begin
                            found_next = 1'b1;
                            if (scan_last)
                            begin
                                cnt_next   = cnt_m1;
                                hit_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                        end
                        else if (cmp_gt || scan_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (cmp_eq)
                        begin
                            hit_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else if (cmp_gt || scan_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_COUNT:
                    begin
                        if (cmp_eq)
                        begin
                            occ_next = occ_reg + CNT_W'(1);
                        end
                        if (cmp_gt || scan_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, rej_reg, cnt_reg == '0,
                                     cnt_reg, occ_reg, hit_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        occ_reg     <= occ_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        rej_reg     <= rej_next;
        m_tdata_reg <= m_tdata_next;
    end

    localparam int HIT_B   = 0;
    localparam int SIZE_LO = 1 + CNT_W;
    localparam int EMPTY_B = 1 + 2 * CNT_W;
    localparam int REJ_B   = 2 + 2 * CNT_W;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("element count above capacity");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && op_t'(s_tuser) == OP_INSERT && cnt_reg == CAP_CNT)
            |=> (cnt_reg == $past(cnt_reg)))
        else $error("refused insert changed the count");

    a_rej_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[REJ_B] && m_tdata_reg[HIT_B]))
        else $error("result both rejected and hit");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[EMPTY_B] ==
                          (m_tdata_reg[SIZE_LO +: CNT_W] == '0)))
        else $error("empty flag disagrees with size");

endmodule

// ===== verif/sorted_multiset_table_core_tb.sv =====
// Sorted multiset table testbench: predictor-backed scoreboard, directed and random traffic.
`timescale 1ns / 1ps

module sorted_multiset_table_core_tb;

    import smt_pkg::*;

    localparam int SLOTS     = 64;
    localparam int RES_W     = 24;
    localparam int MAX_CYCLE = 600000;

    // result word, lowest bit first: hit, occurrences, size, empty_res, rejected
    typedef struct packed {
        logic [6:0] pad;
        logic       rejected;
        logic       empty_res;
        logic [6:0] size;
        logic [6:0] occurrences;
        logic       hit;
    } reply_t;

    class multiset_checker;
        elem_t  contents[$];        // ascending, as the store should hold it
        reply_t pending_replies[$];
        int     fails;
        int     cap;

        function new(int slots);
            cap   = slots;
            fails = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void note_request(op_t op, elem_t value);
            reply_t want;
            int     pos;
            want = '0;
            case (op)
                OP_INSERT:
                begin
                    if (contents.size() >= cap)
                        want.rejected = 1'b1;
                    else
                    begin
                        pos = 0;
                        while (pos < contents.size() && contents[pos] < value)
                            pos++;
                        contents.insert(pos, value);
                        want.hit = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    for (pos = 0; pos < contents.size(); pos++)
                        if (contents[pos] == value)
                            break;
                    if (pos < contents.size())
                    begin
                        contents.delete(pos);
                        want.hit = 1'b1;
                    end
                end
                OP_SEARCH:
                begin
                    foreach (contents[i])
                        if (contents[i] == value)
                            want.hit = 1'b1;
                end
                default:
                begin
                    foreach (contents[i])
                        if (contents[i] == value)
                            want.occurrences++;
                end
            endcase
            want.size      = 7'(contents.size());
            want.empty_res = (contents.size() == 0);
            pending_replies.push_back(want);
        endfunction

        function void check_result(logic [RES_W-1:0] word);
            reply_t got;
            reply_t want;
            bit     bad;
            got = reply_t'(word);
            if (pending_replies.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("result word %h with nothing outstanding", word);
                return;
            end
            want = pending_replies.pop_front();
            bad = (got.hit !== want.hit) || (got.occurrences !== want.occurrences)
                || (got.size !== want.size) || (got.empty_res !== want.empty_res)
                || (got.rejected !== want.rejected) || (got.pad !== 7'd0);
            if (bad)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: want hit=%0d occ=%0d size=%0d empty=%0d rej=%0d, got %h",
                             want.hit, want.occurrences, want.size, want.empty_res,
                             want.rejected, word);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [31:0]      s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [RES_W-1:0] m_tdata;

    multiset_checker sb = new(SLOTS);
    int              cycles = 0;

    always #6 clk = ~clk;

    sorted_multiset_table_core #(.CAPACITY(SLOTS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_request(op_t'(s_tuser), elem_t'(s_tdata));
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure: runs of ready or stall, some of them long and clear
    initial
    begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(20, 150);
                end
                else if ($urandom_range(0, 9) < 1)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
                else
                begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                    hold = $urandom_range(0, 3);
                end
            end
            else
                hold--;
        end
    end

    task automatic send_word(op_t op, elem_t value, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and hold off until every outstanding reply is back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic elem_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.contents.size() != 0)
            return sb.contents[$urandom_range(0, sb.contents.size() - 1)];
        else if (r < 75)
            return elem_t'($signed($urandom_range(0, 15)) - 8);
        return elem_t'($urandom);
    endfunction

    function automatic op_t pick_op(int ins_pct, int rem_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        else if (r < ins_pct + rem_pct)
            return OP_REMOVE;
        return ($urandom_range(0, 1) != 0) ? OP_SEARCH : OP_COUNT;
    endfunction

    task automatic random_run(int n, int ins_pct, int rem_pct, bit with_gaps);
        for (int i = 0; i < n; i++)
            send_word(pick_op(ins_pct, rem_pct), pick_value(), with_gaps ? gap_len() : 0);
    endtask

    initial
    begin
        const elem_t MAXV = 32'sh7fffffff;
        const elem_t MINV = 32'sh80000000;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_INSERT;
        s_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty store first, then extremes and duplicates
        send_word(OP_SEARCH, 5, 0);
        send_word(OP_REMOVE, 5, 1);
        send_word(OP_COUNT, 5, 0);
        send_word(OP_INSERT, MAXV, 0);
        send_word(OP_INSERT, MINV, 0);
        send_word(OP_INSERT, 0, 2);
        send_word(OP_INSERT, -1, 0);
        send_word(OP_INSERT, 0, 0);
        send_word(OP_INSERT, 0, 0);
        send_word(OP_COUNT, 0, 0);
        send_word(OP_COUNT, MINV, 1);
        send_word(OP_SEARCH, MAXV, 0);
        send_word(OP_SEARCH, 1, 0);
        send_word(OP_REMOVE, 7, 0);
        send_word(OP_REMOVE, 0, 3);
        send_word(OP_COUNT, 0, 0);
        send_word(OP_REMOVE, MINV, 0);
        send_word(OP_REMOVE, MAXV, 0);
        send_word(OP_SEARCH, MINV, 0);
        send_word(OP_INSERT, 32'sh55555555, 0);
        send_word(OP_INSERT, 32'shaaaaaaaa, 0);
        send_word(OP_COUNT, -1, 0);
        send_word(OP_REMOVE, -1, 0);
        send_word(OP_REMOVE, 0, 0);
        send_word(OP_REMOVE, 0, 0);

        random_run(150, 40, 25, 1'b1);
        // insert-heavy: runs the store up to full and into refused inserts
        random_run(150, 85, 5, 1'b0);
        quiesce();
        // remove-heavy: drains back down to empty
        random_run(150, 10, 70, 1'b1);
        random_run(250, 40, 30, 1'b1);
        quiesce();

        repeat (SLOTS + 8) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sorted_multiset_table_core.f =====
design/smt_pkg.sv
design/smt_ram.sv
design/sorted_multiset_table_core.sv
verif/sorted_multiset_table_core_tb.sv
